[rtl/ijq_pkg.sv]
// ----------------------------------------------------------------------------
// ijq_pkg: shared types and constants of the indexed min-heap job queue
// Holds the heap entry layout, command and status codes and the ordering rule.
// ----------------------------------------------------------------------------
package ijq_pkg;

	localparam int IdW = 7;
	localparam int IdSpace = 128;

	// Command codes.
	localparam logic [1:0] CMD_INSERT  = 2'd0;
	localparam logic [1:0] CMD_EXTRACT = 2'd1;
	localparam logic [1:0] CMD_HALVE   = 2'd2;
	localparam logic [1:0] CMD_DEC     = 2'd3;

	// Status codes.
	localparam logic [2:0] ST_OK     = 3'd0;
	localparam logic [2:0] ST_EMPTY  = 3'd1;
	localparam logic [2:0] ST_FULL   = 3'd2;
	localparam logic [2:0] ST_ABSENT = 3'd3;
	localparam logic [2:0] ST_DUP    = 3'd4;

	// One heap entry: id, start time, full length and remaining length.
	typedef struct packed {
		logic [IdW-1:0] id;
		logic [15:0]    start;
		logic [15:0]    len;
		logic [15:0]    rem;
	} entry_t;

	// Lower remaining length first; on a tie the lower id first.
	function automatic logic comes_first(entry_t a, entry_t b);
		logic res;
		if (a.rem != b.rem) begin
			res = a.rem < b.rem;
		end else begin
			res = a.id < b.id;
		end
		return res;
	endfunction

endpackage

[rtl/indexed_min_heap_job_queue.sv]
// ----------------------------------------------------------------------------
// indexed_min_heap_job_queue: indexed binary min-heap of jobs
// Jobs ordered by remaining length then id, with an id to slot map.
// ----------------------------------------------------------------------------
// Usage: an input beat (in_valid, in_stall) carries one command: insert,
// extract minimum, halve an unstarted job by id, or decrement the root's
// remaining length. Each command gives exactly one output beat
// (out_valid, out_stall) with a status, the reported job and the count.
// One command is worked at a time; in_stall is high while it runs.
// A decrement, or a command refused at dispatch, finishes at dispatch; a
// halve reads the job's slot first and stops there if the job has started;
// an insert, or a halve of an unstarted job, then sifts the entry up one
// level at a time, and an extract reads the last entry, clears the taken
// id and sifts that entry down from the root. The next command is accepted
// on the edge after the result is loaded.
// Each sift level reads up to two heap entries and writes one back.
// The output register frees the core: while out_stall holds a result, the
// next command is accepted and worked, and waits only to hand its result.
// Reset clears the held count, the id presence flags and both valids.
// The heap memory needs no clearing pass.
// ----------------------------------------------------------------------------
module indexed_min_heap_job_queue #(
	parameter int MAX_JOBS = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [6:0]  job_id,
	input  logic [15:0] start_time,
	input  logic [15:0] job_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  status,
	output logic [6:0]  out_job_id,
	output logic [15:0] out_start_time,
	output logic [15:0] out_length,
	output logic [15:0] out_remaining,
	output logic [6:0]  entry_count
);

	localparam int SW = $clog2(MAX_JOBS);
	localparam logic [SW-1:0] CntMax = SW'(MAX_JOBS - 1);
	localparam logic [SW-1:0] RootSlot = SW'(1);

	typedef enum logic [3:0] {
		S_IDLE, S_DISP, S_HV_RD, S_UP, S_UP_CMP, S_EX_LAST,
		S_DN, S_DN_L, S_DN_R, S_DN_SW, S_FIN
	} state_t;

	state_t          state_q;
	logic [1:0]      cmd_q;
	logic [6:0]      id_q;
	logic [15:0]     start_q;
	logic [15:0]     len_q;
	logic [SW-1:0]   cnt_q;
	logic [SW-1:0]   pos_q;
	logic [SW-1:0]   best_q;
	ijq_pkg::entry_t cur_q;
	ijq_pkg::entry_t best_e_q;
	ijq_pkg::entry_t rep_q;
	ijq_pkg::entry_t root_q;
	logic            have_rep_q;
	logic [2:0]      status_q;

	logic            hw_en;
	logic [SW-1:0]   hw_addr;
	ijq_pkg::entry_t hw_data;
	logic [SW-1:0]   hr_addr;
	ijq_pkg::entry_t hrd;
	logic            mw_en;
	logic [6:0]      mw_id;
	logic [SW-1:0]   mw_slot;
	logic            mclr_en;
	logic [SW-1:0]   map_slot;
	logic            map_vld;
	logic [SW:0]     l_ext;
	logic [SW:0]     r_ext;
	logic            l_ok;
	logic            r_ok;
	logic            out_load;
	ijq_pkg::entry_t rep_sel;

	ijq_heap_mem #(.DEPTH(MAX_JOBS), .AW(SW)) u_heap (
		.clk     (clk),
		.wr_en   (hw_en),
		.wr_addr (hw_addr),
		.wr_data (hw_data),
		.rd_addr (hr_addr),
		.rd_data (hrd)
	);

	ijq_slot_map #(.SW(SW)) u_map (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_id    (job_id),
		.rd_slot  (map_slot),
		.rd_valid (map_vld),
		.wr_en    (mw_en),
		.wr_id    (mw_id),
		.wr_slot  (mw_slot),
		.clr_en   (mclr_en),
		.clr_id   (rep_q.id)
	);

	// Child slots of the current position.
	assign l_ext = {pos_q, 1'b0};
	assign r_ext = l_ext + (SW+1)'(1);
	assign l_ok  = l_ext <= {1'b0, cnt_q};
	assign r_ok  = r_ext <= {1'b0, cnt_q};

	assign in_stall = state_q != S_IDLE;
	assign out_load = (state_q == S_FIN) && (!out_valid || !out_stall);

	// Memory accesses of each step.
	always_comb begin
		hw_en   = 1'b0;
		hw_addr = pos_q;
		hw_data = cur_q;
		hr_addr = pos_q;
		mw_en   = 1'b0;
		mw_id   = cur_q.id;
		mw_slot = pos_q;
		mclr_en = 1'b0;
		case (state_q)
			S_DISP: begin
				if (cmd_q == ijq_pkg::CMD_HALVE) begin
					hr_addr = map_slot;
				end else if (cmd_q == ijq_pkg::CMD_EXTRACT) begin
					hr_addr = cnt_q;
				end else if (cmd_q == ijq_pkg::CMD_DEC && cnt_q != '0
						&& root_q.rem != 16'd0) begin
					hw_en       = 1'b1;
					hw_addr     = RootSlot;
					hw_data     = root_q;
					hw_data.rem = root_q.rem - 16'd1;
				end
			end
			S_UP: begin
				if (pos_q == RootSlot) begin
					hw_en = 1'b1;
					mw_en = 1'b1;
				end else begin
					hr_addr = pos_q >> 1;
				end
			end
			S_UP_CMP: begin
				hw_en = 1'b1;
				mw_en = 1'b1;
				if (ijq_pkg::comes_first(cur_q, hrd)) begin
					hw_data = hrd;
					mw_id   = hrd.id;
				end
			end
			S_EX_LAST: begin
				mclr_en = 1'b1;
			end
			S_DN: begin
				if (l_ok) begin
					hr_addr = l_ext[SW-1:0];
				end else begin
					hw_en = 1'b1;
					mw_en = 1'b1;
				end
			end
			S_DN_L: begin
				hr_addr = r_ext[SW-1:0];
			end
			S_DN_SW: begin
				hw_en = 1'b1;
				mw_en = 1'b1;
				if (best_q != pos_q) begin
					hw_data = best_e_q;
					mw_id   = best_e_q.id;
				end
			end
			default: begin
			end
		endcase
	end

	// Entry reported with the result.
	always_comb begin
		if (have_rep_q) begin
			rep_sel = rep_q;
		end else if (cnt_q != '0) begin
			rep_sel = root_q;
		end else begin
			rep_sel = '0;
		end
	end

	// Mirror of the root slot, kept in step with every write to it.
	always_ff @(posedge clk) begin
		if (hw_en && hw_addr == RootSlot) begin
			root_q <= hw_data;
		end
	end

	// Sequencer, working registers and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			cnt_q      <= '0;
			out_valid  <= 1'b0;
			have_rep_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						cmd_q      <= command;
						id_q       <= job_id;
						start_q    <= start_time;
						len_q      <= job_length;
						have_rep_q <= 1'b0;
						status_q   <= ijq_pkg::ST_OK;
						state_q    <= S_DISP;
					end
				end
				S_DISP: begin
					state_q <= S_FIN;
					case (cmd_q)
						ijq_pkg::CMD_INSERT: begin
							if (map_vld) begin
								status_q <= ijq_pkg::ST_DUP;
							end else if (cnt_q >= CntMax) begin
								status_q <= ijq_pkg::ST_FULL;
							end else begin
								cnt_q   <= cnt_q + SW'(1);
								pos_q   <= cnt_q + SW'(1);
								cur_q   <= '{id: id_q, start: start_q, len: len_q, rem: len_q};
								state_q <= S_UP;
							end
						end
						ijq_pkg::CMD_EXTRACT: begin
							if (cnt_q == '0) begin
								status_q <= ijq_pkg::ST_EMPTY;
							end else begin
								rep_q      <= root_q;
								have_rep_q <= 1'b1;
								state_q    <= S_EX_LAST;
							end
						end
						ijq_pkg::CMD_HALVE: begin
							if (!map_vld) begin
								status_q <= ijq_pkg::ST_ABSENT;
							end else begin
								pos_q   <= map_slot;
								state_q <= S_HV_RD;
							end
						end
						default: begin
							if (cnt_q == '0) begin
								status_q <= ijq_pkg::ST_EMPTY;
							end
						end
					endcase
				end
				S_HV_RD: begin
					if (hrd.rem != hrd.len) begin
						status_q <= ijq_pkg::ST_ABSENT;
						state_q  <= S_FIN;
					end else begin
						cur_q   <= '{id: hrd.id, start: hrd.start, len: hrd.len >> 1,
							rem: hrd.rem >> 1};
						state_q <= S_UP;
					end
				end
				S_UP: begin
					state_q <= (pos_q == RootSlot) ? S_FIN : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (ijq_pkg::comes_first(cur_q, hrd)) begin
						pos_q   <= pos_q >> 1;
						state_q <= S_UP;
					end else begin
						state_q <= S_FIN;
					end
				end
				S_EX_LAST: begin
					cnt_q <= cnt_q - SW'(1);
					if (cnt_q == RootSlot) begin
						state_q <= S_FIN;
					end else begin
						cur_q   <= hrd;
						pos_q   <= RootSlot;
						state_q <= S_DN;
					end
				end
				S_DN: begin
					state_q <= l_ok ? S_DN_L : S_FIN;
				end
				S_DN_L: begin
					if (ijq_pkg::comes_first(hrd, cur_q)) begin
						best_q   <= l_ext[SW-1:0];
						best_e_q <= hrd;
					end else begin
						best_q   <= pos_q;
						best_e_q <= cur_q;
					end
					state_q <= r_ok ? S_DN_R : S_DN_SW;
				end
				S_DN_R: begin
					if (ijq_pkg::comes_first(hrd, best_e_q)) begin
						best_q   <= r_ext[SW-1:0];
						best_e_q <= hrd;
					end
					state_q <= S_DN_SW;
				end
				S_DN_SW: begin
					if (best_q == pos_q) begin
						state_q <= S_FIN;
					end else begin
						pos_q   <= best_q;
						state_q <= S_DN;
					end
				end
				S_FIN: begin
					if (out_load) begin
						status         <= status_q;
						out_job_id     <= rep_sel.id;
						out_start_time <= rep_sel.start;
						out_length     <= rep_sel.len;
						out_remaining  <= rep_sel.rem;
						entry_count    <= 7'(cnt_q);
						state_q        <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The held count never passes the heap capacity.
	a_cnt_cap: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CntMax)
		else $error("held count above capacity");

	// Heap writes land only in occupied slots.
	a_wr_slot: assert property (@(posedge clk) disable iff (!arst_n)
		hw_en |-> (hw_addr != '0 && hw_addr <= cnt_q))
		else $error("heap write outside occupied slots");

	// A result is loaded only from the finish step.
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == S_FIN))
		else $error("result raised outside finish step");

	// A command leaves the finish step only by delivering its result.
	a_fin_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FIN && out_valid && out_stall) |=> state_q == S_FIN)
		else $error("finish step left while output held");

endmodule

[rtl/ijq_heap_mem.sv]
// ----------------------------------------------------------------------------
// ijq_heap_mem: heap entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ijq_heap_mem #(
	parameter int DEPTH = 128,
	parameter int AW = 7
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  ijq_pkg::entry_t   wr_data,
	input  logic [AW-1:0]     rd_addr,
	output ijq_pkg::entry_t   rd_data
);

	ijq_pkg::entry_t mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rd_data <= mem[rd_addr];
	end

endmodule

[rtl/ijq_slot_map.sv]
// ----------------------------------------------------------------------------
// ijq_slot_map: job id to heap slot map
// Slot memory with registered read, plus one presence flag per job id.
// ----------------------------------------------------------------------------
module ijq_slot_map #(
	parameter int SW = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [ijq_pkg::IdW-1:0] rd_id,
	output logic [SW-1:0]           rd_slot,
	output logic                    rd_valid,
	input  logic                    wr_en,
	input  logic [ijq_pkg::IdW-1:0] wr_id,
	input  logic [SW-1:0]           wr_slot,
	input  logic                    clr_en,
	input  logic [ijq_pkg::IdW-1:0] clr_id
);

	logic [SW-1:0]               slot_mem [ijq_pkg::IdSpace];
	logic [ijq_pkg::IdSpace-1:0] present_q;

	// Slot memory.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			slot_mem[wr_id] <= wr_slot;
		end
		rd_slot <= slot_mem[rd_id];
	end

	// Presence flags; a write marks the id present, a clear marks it absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= '0;
			rd_valid  <= 1'b0;
		end else begin
			if (wr_en) begin
				present_q[wr_id] <= 1'b1;
			end
			if (clr_en) begin
				present_q[clr_id] <= 1'b0;
			end
			rd_valid <= present_q[rd_id];
		end
	end

endmodule
